FILE: hw/rtl/smc_pkg.sv
package smc_pkg;

    localparam int COUNT_BITS = 64;
    localparam int VAL_W      = COUNT_BITS - 1;
    localparam int PROD_W     = 2 * COUNT_BITS;

    localparam logic [1:0] OP_BINOM     = 2'd0;
    localparam logic [1:0] OP_FACT      = 2'd1;
    localparam logic [1:0] OP_MULTI_EXP = 2'd2;
    localparam logic [1:0] OP_MULTI_SUM = 2'd3;

    localparam logic [1:0] OUT_NORMAL = 2'd0;
    localparam logic [1:0] OUT_SAT    = 2'd1;
    localparam logic [1:0] OUT_FAIL   = 2'd2;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic                         first;
        logic                         last;
        logic signed [COUNT_BITS-1:0] total;
        logic signed [COUNT_BITS-1:0] part;
    } in_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             saturated;
    } out_res_t;

endpackage

FILE: hw/rtl/saturating_multinomial_coefficient_core.sv
// Binomial: one multiply-divide step (shared 32x32 multiplier, radix-256 divider)
// for each of up to min(r, n-r) steps, at most 63; factorial: one capped multiply
// per step until the limit or n is reached; group items with a nonzero part add one
// binomial plus one capped multiply. One request at a time: in_stall holds off new
// requests until done. Reset clears run state and sets the limit to all ones.
module saturating_multinomial_coefficient_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  smc_pkg::in_req_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output smc_pkg::out_res_t                out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smc_pkg::VAL_W-1:0]        cfg_data
);

    localparam int CW = smc_pkg::COUNT_BITS;
    localparam int VW = smc_pkg::VAL_W;
    localparam int PW = smc_pkg::PROD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BINIT = 4'd1;
    localparam logic [3:0] S_BCHK  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_BDIV  = 4'd4;
    localparam logic [3:0] S_BEND  = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_FEND  = 4'd7;
    localparam logic [3:0] S_CONT  = 4'd8;
    localparam logic [3:0] S_MEND  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [1:0] C_OUT   = 2'd0;
    localparam logic [1:0] C_RUN   = 2'd1;
    localparam logic [1:0] C_FINAL = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    mret_reg, mret_next;
    logic [1:0]    cont_reg, cont_next;
    logic [1:0]    op_reg, op_next;
    logic          last_reg, last_next;
    logic [VW-1:0] limit_reg, limit_next;
    logic [VW-1:0] run_product_reg, run_product_next;
    logic [CW-1:0] run_remaining_reg, run_remaining_next;
    logic [CW-1:0] run_sum_reg, run_sum_next;
    logic [1:0]    run_outcome_reg, run_outcome_next;
    logic [CW-1:0] bn_reg, bn_next;
    logic [CW-1:0] br_reg, br_next;
    logic [CW-1:0] bk_reg, bk_next;
    logic [6:0]    bi_reg, bi_next;
    logic [VW-1:0] bres_reg, bres_next;
    logic [VW-1:0] sub_res_reg, sub_res_next;
    logic [VW-1:0] ma_reg, ma_next;
    logic [CW-1:0] mb_reg, mb_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [1:0]    mcnt_reg, mcnt_next;
    logic [3:0]    dcnt_reg, dcnt_next;
    logic [5:0]    rem_reg, rem_next;
    logic [VW-1:0] res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    smc_pkg::out_res_t out_data_reg, out_data_next;

    logic [31:0]   pa, pb;
    logic [63:0]   pp;
    logic [PW-1:0] pp_sh;
    logic [7:0]    q8;
    logic [5:0]    drem;
    logic [VW-1:0] mmin;
    logic          mge;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign mge  = (acc_reg >= {{(PW-VW){1'b0}}, limit_reg});
    assign mmin = mge ? limit_reg : acc_reg[VW-1:0];

    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:
            begin
                pa = ma_reg[31:0];
                pb = mb_reg[31:0];
            end
            2'd1:
            begin
                pa = ma_reg[31:0];
                pb = mb_reg[63:32];
            end
            2'd2:
            begin
                pa = {1'b0, ma_reg[62:32]};
                pb = mb_reg[31:0];
            end
            default:
            begin
                pa = {1'b0, ma_reg[62:32]};
                pb = mb_reg[63:32];
            end
        endcase
        pp = pa * pb;
        unique case (mcnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb
    begin
        logic [6:0] t;
        logic [5:0] r;
        r  = rem_reg;
        q8 = '0;
        for (int j = 0; j < 8; j++)
        begin
            t = {r, acc_reg[PW-1-j]};
            if (t >= bi_reg)
            begin
                t = t - bi_reg;
                q8[7-j] = 1'b1;
            end
            r = t[5:0];
        end
        drem = r;
    end

    always_comb
    begin
        logic [CW-1:0] tot_u, part_u, rr1, rs1, diff, kk;
        logic [VW-1:0] rp1;
        logic [1:0]    ro1;
        logic          tneg, pneg;

        state_next         = state_reg;
        mret_next          = mret_reg;
        cont_next          = cont_reg;
        op_next            = op_reg;
        last_next          = last_reg;
        limit_next         = limit_reg;
        run_product_next   = run_product_reg;
        run_remaining_next = run_remaining_reg;
        run_sum_next       = run_sum_reg;
        run_outcome_next   = run_outcome_reg;
        bn_next            = bn_reg;
        br_next            = br_reg;
        bk_next            = bk_reg;
        bi_next            = bi_reg;
        bres_next          = bres_reg;
        sub_res_next       = sub_res_reg;
        ma_next            = ma_reg;
        mb_next            = mb_reg;
        acc_next           = acc_reg;
        mcnt_next          = mcnt_reg;
        dcnt_next          = dcnt_reg;
        rem_next           = rem_reg;
        res_next           = res_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;

        tot_u  = in_data.total;
        part_u = in_data.part;
        tneg   = tot_u[CW-1];
        pneg   = part_u[CW-1];
        rp1    = in_data.first ? {{(VW-1){1'b0}}, 1'b1} : run_product_reg;
        rs1    = in_data.first ? '0 : run_sum_reg;
        rr1    = (in_data.first && in_data.opcode == smc_pkg::OP_MULTI_EXP)
                 ? (tneg ? '0 : tot_u) : run_remaining_reg;
        ro1    = in_data.first
                 ? ((in_data.opcode == smc_pkg::OP_MULTI_EXP && tneg)
                    ? smc_pkg::OUT_FAIL : smc_pkg::OUT_NORMAL)
                 : run_outcome_reg;
        diff   = bn_reg - br_reg;
        kk     = (diff < br_reg) ? diff : br_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_data.opcode;
                    last_next = in_data.last;
                    unique case (in_data.opcode)
                        smc_pkg::OP_BINOM:
                        begin
                            if (tneg || pneg || part_u > tot_u)
                            begin
                                res_next   = '0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                bn_next    = tot_u;
                                br_next    = part_u;
                                cont_next  = C_OUT;
                                state_next = S_BINIT;
                            end
                        end
                        smc_pkg::OP_FACT:
                        begin
                            if (tneg)
                            begin
                                res_next   = '0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                bn_next    = tot_u;
                                bi_next    = 7'd2;
                                bres_next  = {{(VW-1){1'b0}}, 1'b1};
                                cont_next  = C_OUT;
                                state_next = S_FCHK;
                            end
                        end
                        default:
                        begin
                            run_product_next   = rp1;
                            run_sum_next       = rs1;
                            run_remaining_next = rr1;
                            run_outcome_next   = ro1;
                            state_next         = S_FIN;
                            if (ro1 == smc_pkg::OUT_NORMAL)
                            begin
                                if (pneg || (in_data.opcode == smc_pkg::OP_MULTI_EXP
                                             && part_u > rr1))
                                begin
                                    run_outcome_next = smc_pkg::OUT_FAIL;
                                end
                                else if (part_u != '0)
                                begin
                                    br_next    = part_u;
                                    cont_next  = C_RUN;
                                    state_next = S_BINIT;
                                    if (in_data.opcode == smc_pkg::OP_MULTI_EXP)
                                    begin
                                        bn_next            = rr1;
                                        run_remaining_next = rr1 - part_u;
                                    end
                                    else
                                    begin
                                        bn_next      = rs1 + part_u;
                                        run_sum_next = rs1 + part_u;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_BINIT:
            begin
                if (limit_reg <= {{(VW-1){1'b0}}, 1'b1})
                begin
                    sub_res_next = limit_reg;
                    state_next   = S_CONT;
                end
                else
                begin
                    bk_next    = kk;
                    bn_next    = bn_reg - kk;
                    bi_next    = 7'd1;
                    bres_next  = {{(VW-1){1'b0}}, 1'b1};
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if ({{(CW-7){1'b0}}, bi_reg} > bk_reg)
                begin
                    sub_res_next = bres_reg;
                    state_next   = S_CONT;
                end
                else if (bi_reg[6])
                begin
                    sub_res_next = limit_reg;
                    state_next   = S_CONT;
                end
                else
                begin
                    ma_next    = bres_reg;
                    mb_next    = bn_reg + {{(CW-7){1'b0}}, bi_reg};
                    acc_next   = '0;
                    mcnt_next  = '0;
                    dcnt_next  = '0;
                    rem_next   = '0;
                    mret_next  = S_BDIV;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next  = acc_reg + pp_sh;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = mret_reg;
                end
            end
            S_BDIV:
            begin
                acc_next  = {acc_reg[PW-9:0], q8};
                rem_next  = drem;
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd15)
                begin
                    state_next = S_BEND;
                end
            end
            S_BEND:
            begin
                if (acc_reg[PW-1:CW] != '0
                    || acc_reg[CW-1:0] >= {1'b0, limit_reg})
                begin
                    sub_res_next = limit_reg;
                    state_next   = S_CONT;
                end
                else
                begin
                    bres_next  = acc_reg[VW-1:0];
                    bi_next    = bi_reg + 7'd1;
                    state_next = S_BCHK;
                end
            end
            S_FCHK:
            begin
                if ({{(CW-7){1'b0}}, bi_reg} > bn_reg)
                begin
                    sub_res_next = (bres_reg < limit_reg) ? bres_reg : limit_reg;
                    state_next   = S_CONT;
                end
                else
                begin
                    ma_next    = bres_reg;
                    mb_next    = {{(CW-7){1'b0}}, bi_reg};
                    acc_next   = '0;
                    mcnt_next  = '0;
                    mret_next  = S_FEND;
                    state_next = S_MUL;
                end
            end
            S_FEND:
            begin
                if (mge)
                begin
                    sub_res_next = limit_reg;
                    state_next   = S_CONT;
                end
                else
                begin
                    bres_next  = mmin;
                    bi_next    = bi_reg + 7'd1;
                    state_next = S_FCHK;
                end
            end
            S_CONT:
            begin
                if (cont_reg == C_OUT)
                begin
                    res_next   = sub_res_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    ma_next    = run_product_reg;
                    mb_next    = {1'b0, sub_res_reg};
                    acc_next   = '0;
                    mcnt_next  = '0;
                    mret_next  = S_MEND;
                    state_next = S_MUL;
                end
            end
            S_MEND:
            begin
                if (cont_reg == C_RUN)
                begin
                    run_product_next = mmin;
                    if (mge)
                    begin
                        run_outcome_next = smc_pkg::OUT_SAT;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    res_next   = mmin;
                    state_next = S_OUT;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (run_outcome_reg == smc_pkg::OUT_FAIL)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else if (run_outcome_reg == smc_pkg::OUT_SAT)
                begin
                    res_next   = limit_reg;
                    state_next = S_OUT;
                end
                else if (op_reg == smc_pkg::OP_MULTI_EXP
                         && run_remaining_reg > {{(CW-1){1'b0}}, 1'b1})
                begin
                    bn_next    = run_remaining_reg;
                    bi_next    = 7'd2;
                    bres_next  = {{(VW-1){1'b0}}, 1'b1};
                    cont_next  = C_FINAL;
                    state_next = S_FCHK;
                end
                else
                begin
                    res_next   = (run_product_reg < limit_reg) ? run_product_reg
                                                               : limit_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.value     = res_reg;
                    out_data_next.saturated = (res_reg >= limit_reg);
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mret_reg          <= S_IDLE;
            cont_reg          <= C_OUT;
            mcnt_reg          <= '0;
            dcnt_reg          <= '0;
            limit_reg         <= '1;
            run_product_reg   <= {{(VW-1){1'b0}}, 1'b1};
            run_remaining_reg <= '0;
            run_sum_reg       <= '0;
            run_outcome_reg   <= smc_pkg::OUT_NORMAL;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mret_reg          <= mret_next;
            cont_reg          <= cont_next;
            mcnt_reg          <= mcnt_next;
            dcnt_reg          <= dcnt_next;
            limit_reg         <= limit_next;
            run_product_reg   <= run_product_next;
            run_remaining_reg <= run_remaining_next;
            run_sum_reg       <= run_sum_next;
            run_outcome_reg   <= run_outcome_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        bn_reg       <= bn_next;
        br_reg       <= br_next;
        bk_reg       <= bk_next;
        bi_reg       <= bi_next;
        bres_reg     <= bres_next;
        sub_res_reg  <= sub_res_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule
